[hw/rtl/otce_pkg.sv]
// ----------------------------------------------------------------------------
// otce_pkg
// shared types, character codes and ascii helpers for the trouble code extractor
// ----------------------------------------------------------------------------
package otce_pkg;

  // result kinds
  localparam logic KIND_CODE  = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  // characters of interest
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;

  // response header bytes
  localparam logic [7:0] HDR_STORED  = 8'h43;
  localparam logic [7:0] HDR_PENDING = 8'h47;
  localparam logic [7:0] HDR_PERM    = 8'h4A;

  localparam logic [5:0] MAX_CODES_RST = 6'd32;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  typedef struct packed {
    logic        kind;
    logic [15:0] raw;
    logic [5:0]  found;
  } otce_result_t;

  typedef struct packed {
    logic [1:0]   n;
    otce_result_t a;
    otce_result_t b;
  } otce_push_t;

  typedef struct packed {
    logic [FIFO_CW-1:0] count;
  } otce_qstat_t;

  function automatic logic [7:0] hex_ascii(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = CH_ZERO + {4'd0, v};
    end else begin
      r = CH_UA + {4'd0, v} - 8'd10;
    end
    return r;
  endfunction

  function automatic logic [7:0] sys_letter(input logic [1:0] s);
    logic [7:0] r;
    unique case (s)
      2'd0: r = 8'h50;
      2'd1: r = 8'h43;
      2'd2: r = 8'h42;
      2'd3: r = 8'h55;
      default: r = 8'h50;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/obd_trouble_code_extractor.sv]
// ----------------------------------------------------------------------------
// obd_trouble_code_extractor
// parses adapter response text into diagnostic trouble codes and a count
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | content
//  --------+-----+--------------------+------------------------------------------
//  in_     | in  | in_tvalid/tready   | tdata text_char, tlast end_of_response
//  out_    | out | out_tvalid/tready  | tdata code fields + count, tuser kind,
//          |     |                    | tlast last_of_run
//  cfg_    | in  | cfg_we             | cfg_wdata max_codes
//
// one character per cycle: the parser state updates in the accept cycle and
// its results land in a four-entry result queue, drained one per cycle while
// out_tready is high; a result shows on out_ once the results ahead of it
// have left the queue; in_tready drops while fewer than two queue entries are
// free, since one character can produce a code and a count result
// synchronous active-low reset clears parser state and queue, max_codes -> 32
// ----------------------------------------------------------------------------
module obd_trouble_code_extractor #(
  parameter int MAX_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input transaction
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] text_char
  input  logic        in_tlast,    // end_of_response
  // result transaction
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [15:0] code_raw, [23:16] system_letter,
                                   // [31:24] group_digit, [39:32] hex_char_high,
                                   // [47:40] hex_char_mid, [55:48] hex_char_low,
                                   // [61:56] codes_found, [63:62] zero
  output logic        out_tuser,   // result_kind
  output logic        out_tlast,   // last_of_run
  // configuration
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata    // max_codes
);

  otce_pkg::otce_push_t   push;
  otce_pkg::otce_result_t head;
  otce_pkg::otce_qstat_t  qstat;
  logic                   in_acc;

  // room for the worst case of two results
  assign in_tready = (qstat.count <= otce_pkg::FIFO_CW'(otce_pkg::FIFO_DEPTH - 2));
  assign in_acc    = in_tvalid && in_tready;

  // character parser and byte/code assembly
  otce_scan #(
    .MAX_BYTES (MAX_BYTES)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .acc       (in_acc),
    .text_char (in_tdata),
    .end_flag  (in_tlast),
    .push      (push)
  );

  // result queue decouples the output stall from the parser
  otce_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_acc),
    .wr       (push),
    .rd_en    (out_tready),
    .rd_data  (head),
    .rd_valid (out_tvalid),
    .stat     (qstat)
  );

  // ascii formatting of the queue head
  otce_fmt u_fmt (
    .res   (head),
    .tdata (out_tdata),
    .kind  (out_tuser),
    .last  (out_tlast)
  );

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= otce_pkg::FIFO_CW'(otce_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> out_tvalid)
    else $error("end of response without pending result");

  a_last_is_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tuser == otce_pkg::KIND_COUNT &&
                                   out_tdata[15:0] == 16'd0))
    else $error("last result is not a clean count result");
`endif

endmodule

[hw/rtl/otce_scan.sv]
// ----------------------------------------------------------------------------
// otce_scan
// per-character parser state, byte assembly and trouble code pairing
// ----------------------------------------------------------------------------
module otce_scan #(
  parameter int MAX_BYTES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [5:0]          cfg_wdata,
  input  logic                acc,
  input  logic [7:0]          text_char,
  input  logic                end_flag,
  output otce_pkg::otce_push_t push
);

  localparam int BCW = $clog2(MAX_BYTES + 1);

  typedef struct packed {
    logic [3:0]     hi_nib;
    logic           hi_v;
    logic [3:0]     held;
    logic           held_v;
    logic [BCW-1:0] bytes;
    logic           hdr;
    logic [7:0]     first;
    logic           first_v;
    logic [5:0]     emitted;
    logic           stopped;
  } scan_st_t;

  scan_st_t   st_r, st_nxt;
  logic [5:0] max_codes_r;

  // one hex digit into the byte assembler
  function automatic scan_st_t take_nib(input scan_st_t s, input logic [3:0] v,
                                        input logic [5:0] maxc, output logic emit,
                                        output logic [15:0] raw);
    scan_st_t   n;
    logic [7:0] b;
    n    = s;
    emit = 1'b0;
    raw  = 16'd0;
    b    = {s.hi_nib, v};
    if (s.bytes < BCW'(MAX_BYTES)) begin
      if (!s.hi_v) begin
        n.hi_nib = v;
        n.hi_v   = 1'b1;
      end else begin
        n.hi_v  = 1'b0;
        n.bytes = s.bytes + BCW'(1);
        if (!s.hdr) begin
          if ((b == otce_pkg::HDR_STORED || b == otce_pkg::HDR_PENDING ||
               b == otce_pkg::HDR_PERM) && s.emitted < maxc) begin
            n.hdr = 1'b1;
          end
        end else if (!s.first_v) begin
          n.first   = b;
          n.first_v = 1'b1;
        end else begin
          n.first_v = 1'b0;
          if ({s.first, b} != 16'd0 && s.emitted < maxc) begin
            emit      = 1'b1;
            raw       = {s.first, b};
            n.emitted = s.emitted + 6'd1;
          end
        end
      end
    end
    return n;
  endfunction

  always_comb begin
    scan_st_t    s;
    logic        e1, e2, e3;
    logic [15:0] r1, r2, r3;
    logic        skip;
    logic        code_v;
    otce_pkg::otce_result_t code_res, cnt_res;
    s    = st_r;
    e1   = 1'b0;
    e2   = 1'b0;
    e3   = 1'b0;
    r1   = 16'd0;
    r2   = 16'd0;
    r3   = 16'd0;
    skip = 1'b0;
    if (!s.stopped) begin
      if (text_char == otce_pkg::CH_NUL) begin
        if (s.held_v) begin
          s.held_v = 1'b0;
          s = take_nib(s, s.held, max_codes_r, e1, r1);
        end
        s.stopped = 1'b1;
      end else begin
        if (s.held_v) begin
          s.held_v = 1'b0;
          if (text_char == otce_pkg::CH_COLON) begin
            // line number: drop digit and half-built byte
            s.hi_v = 1'b0;
            skip   = 1'b1;
          end else begin
            s = take_nib(s, s.held, max_codes_r, e1, r1);
          end
        end
        if (!skip && s.bytes < BCW'(MAX_BYTES)) begin
          priority if (text_char == otce_pkg::CH_SPACE || text_char == otce_pkg::CH_TAB ||
                       text_char == otce_pkg::CH_COLON) begin
            s.hi_v = s.hi_v;
          end else if (text_char == otce_pkg::CH_CR || text_char == otce_pkg::CH_LF) begin
            s.hi_v = 1'b0;
          end else if (text_char >= otce_pkg::CH_ZERO && text_char <= otce_pkg::CH_NINE) begin
            s.held   = text_char[3:0];
            s.held_v = 1'b1;
          end else if ((text_char >= otce_pkg::CH_UA && text_char <= otce_pkg::CH_UF) ||
                       (text_char >= otce_pkg::CH_LA &&
                        text_char <= otce_pkg::CH_LF_HEX)) begin
            s = take_nib(s, text_char[3:0] + 4'd9, max_codes_r, e2, r2);
          end else begin
            s.hi_v = s.hi_v;
          end
        end
      end
    end
    if (end_flag && s.held_v) begin
      s.held_v = 1'b0;
      s = take_nib(s, s.held, max_codes_r, e3, r3);
    end
    // at most one byte completes per character, so at most one code
    code_v         = e1 | e2 | e3;
    code_res.kind  = otce_pkg::KIND_CODE;
    code_res.raw   = r1 | r2 | r3;
    code_res.found = 6'd0;
    cnt_res.kind   = otce_pkg::KIND_COUNT;
    cnt_res.raw    = 16'd0;
    cnt_res.found  = s.emitted;
    push.n = {1'b0, code_v} + {1'b0, end_flag};
    push.a = code_v ? code_res : cnt_res;
    push.b = cnt_res;
    if (end_flag) begin
      s = '0;
    end
    st_nxt = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      max_codes_r <= otce_pkg::MAX_CODES_RST;
    end else begin
      if (acc) begin
        st_r <= st_nxt;
      end
      if (cfg_we) begin
        max_codes_r <= cfg_wdata;
      end
    end
  end

endmodule

[hw/rtl/otce_fifo.sv]
// ----------------------------------------------------------------------------
// otce_fifo
// small result queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
module otce_fifo (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  otce_pkg::otce_push_t     wr,
  input  logic                     rd_en,
  output otce_pkg::otce_result_t   rd_data,
  output logic                     rd_valid,
  output otce_pkg::otce_qstat_t    stat
);

  otce_pkg::otce_result_t mem [otce_pkg::FIFO_DEPTH];
  logic [otce_pkg::FIFO_AW-1:0] wp_r, rp_r;
  logic [otce_pkg::FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic [1:0] n_wr;

  assign n_wr     = wr_en ? wr.n : 2'd0;
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem[rp_r];
  assign cnt_nxt  = cnt_r + otce_pkg::FIFO_CW'(n_wr)
                    - otce_pkg::FIFO_CW'(rd_en && rd_valid);
  assign stat.count = cnt_r;

  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) begin
      mem[wp_r] <= wr.a;
    end
    if (n_wr == 2'd2) begin
      mem[wp_r + otce_pkg::FIFO_AW'(1)] <= wr.b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + otce_pkg::FIFO_AW'(n_wr);
      if (rd_en && rd_valid) begin
        rp_r <= rp_r + otce_pkg::FIFO_AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[hw/rtl/otce_fmt.sv]
// ----------------------------------------------------------------------------
// otce_fmt
// turns a queued result into raw code, ascii code characters and count
// ----------------------------------------------------------------------------
module otce_fmt (
  input  otce_pkg::otce_result_t res,
  output logic [63:0]            tdata,
  output logic                   kind,
  output logic                   last
);

  logic [7:0] sys_c, grp_c, hh_c, hm_c, hl_c;

  always_comb begin
    if (res.kind == otce_pkg::KIND_CODE) begin
      sys_c = otce_pkg::sys_letter(res.raw[15:14]);
      grp_c = otce_pkg::CH_ZERO + {6'd0, res.raw[13:12]};
      hh_c  = otce_pkg::hex_ascii(res.raw[11:8]);
      hm_c  = otce_pkg::hex_ascii(res.raw[7:4]);
      hl_c  = otce_pkg::hex_ascii(res.raw[3:0]);
    end else begin
      sys_c = 8'd0;
      grp_c = 8'd0;
      hh_c  = 8'd0;
      hm_c  = 8'd0;
      hl_c  = 8'd0;
    end
  end

  assign tdata = {2'b00, res.found, hl_c, hm_c, hh_c, grp_c, sys_c, res.raw};
  assign kind  = res.kind;
  assign last  = (res.kind == otce_pkg::KIND_COUNT);

endmodule

[verif/otce_result_checker.sv]
// ----------------------------------------------------------------------------
// otce_result_checker
// passive checker for the trouble code extractor: follows every character
// transaction on the input side, predicts the code and count results it
// causes, and compares them field by field with the result transactions
// ----------------------------------------------------------------------------
module otce_result_checker #(
  parameter int MAX_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  output int          fail_count,
  output int          results_due
);

  typedef struct {
    logic        kind;
    logic [15:0] raw;
    logic [7:0]  letter;
    logic [7:0]  group;
    logic [7:0]  hex_hi;
    logic [7:0]  hex_mid;
    logic [7:0]  hex_lo;
    logic [5:0]  found;
    logic        last;
  } dtc_result_t;

  dtc_result_t dtc_q[$];
  int          mismatch_total = 0;

  // parser image
  logic [5:0] code_limit;
  logic [3:0] nib;
  logic       nib_ok;
  logic [3:0] digit;
  logic       digit_ok;
  logic [6:0] byte_count;
  logic       hdr_seen;
  logic [7:0] lead_byte;
  logic       lead_ok;
  logic [5:0] codes_out;
  logic       halted;

  assign fail_count = mismatch_total;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return otce_pkg::CH_ZERO + {4'd0, v};
    return otce_pkg::CH_UA + {4'd0, v} - 8'd10;
  endfunction

  function automatic dtc_result_t code_result(input logic [15:0] raw);
    dtc_result_t r;
    r.kind = otce_pkg::KIND_CODE;
    r.raw  = raw;
    case (raw[15:14])
      2'd0: r.letter = "P";
      2'd1: r.letter = "C";
      2'd2: r.letter = "B";
      default: r.letter = "U";
    endcase
    r.group   = otce_pkg::CH_ZERO + {6'd0, raw[13:12]};
    r.hex_hi  = hex_char(raw[11:8]);
    r.hex_mid = hex_char(raw[7:4]);
    r.hex_lo  = hex_char(raw[3:0]);
    r.found   = '0;
    r.last    = 1'b0;
    return r;
  endfunction

  task automatic clear_parser;
    nib = '0;        nib_ok = 1'b0;
    digit = '0;      digit_ok = 1'b0;
    byte_count = '0; hdr_seen = 1'b0;
    lead_byte = '0;  lead_ok = 1'b0;
    codes_out = '0;  halted = 1'b0;
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    logic [15:0] raw;
    if (!hdr_seen) begin
      if ((b == otce_pkg::HDR_STORED || b == otce_pkg::HDR_PENDING ||
           b == otce_pkg::HDR_PERM) && codes_out < code_limit)
        hdr_seen = 1'b1;
    end else if (!lead_ok) begin
      lead_byte = b;
      lead_ok   = 1'b1;
    end else begin
      lead_ok = 1'b0;
      raw = {lead_byte, b};
      // all-zero pairs are padding, not codes
      if (raw != 16'h0000 && codes_out < code_limit) begin
        codes_out = codes_out + 6'd1;
        dtc_q.push_back(code_result(raw));
      end
    end
  endtask

  task automatic absorb_nibble(input logic [3:0] v);
    if (byte_count < MAX_BYTES) begin
      if (!nib_ok) begin
        nib    = v;
        nib_ok = 1'b1;
      end else begin
        nib_ok     = 1'b0;
        byte_count = byte_count + 7'd1;
        absorb_byte({nib, v});
      end
    end
  endtask

  task automatic release_held;
    if (digit_ok) begin
      digit_ok = 1'b0;
      absorb_nibble(digit);
    end
  endtask

  task automatic parse_char(input logic [7:0] c);
    logic [7:0] t;
    if (digit_ok && c == otce_pkg::CH_COLON) begin
      // line number: drop it together with any half byte
      digit_ok = 1'b0;
      nib_ok   = 1'b0;
    end else begin
      release_held();
      if (byte_count < MAX_BYTES) begin
        if (c == otce_pkg::CH_SPACE || c == otce_pkg::CH_TAB ||
            c == otce_pkg::CH_COLON) begin
        end else if (c == otce_pkg::CH_CR || c == otce_pkg::CH_LF) begin
          nib_ok = 1'b0;
        end else if (c >= otce_pkg::CH_ZERO && c <= otce_pkg::CH_NINE) begin
          t        = c - otce_pkg::CH_ZERO;
          digit    = t[3:0];
          digit_ok = 1'b1;
        end else if (c >= otce_pkg::CH_UA && c <= otce_pkg::CH_UF) begin
          t = c - otce_pkg::CH_UA + 8'd10;
          absorb_nibble(t[3:0]);
        end else if (c >= otce_pkg::CH_LA && c <= otce_pkg::CH_LF_HEX) begin
          t = c - otce_pkg::CH_LA + 8'd10;
          absorb_nibble(t[3:0]);
        end
      end
    end
  endtask

  task automatic step_char(input logic [7:0] c, input logic last);
    dtc_result_t cnt;
    if (!halted) begin
      if (c == otce_pkg::CH_NUL) begin
        release_held();
        halted = 1'b1;
      end else begin
        parse_char(c);
      end
    end
    if (last) begin
      release_held();
      cnt         = code_result(16'h0000);
      cnt.kind    = otce_pkg::KIND_COUNT;
      cnt.letter  = '0;
      cnt.group   = '0;
      cnt.hex_hi  = '0;
      cnt.hex_mid = '0;
      cnt.hex_lo  = '0;
      cnt.found   = codes_out;
      cnt.last    = 1'b1;
      dtc_q.push_back(cnt);
      clear_parser();
    end
  endtask

  task automatic compare_field(input string label, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", label, want, got);
      mismatch_total++;
    end
  endtask

  task automatic check_result;
    dtc_result_t e;
    if (dtc_q.size() == 0) begin
      $error("result transaction with nothing expected: kind %0h tdata %0h",
             out_tuser, out_tdata);
      mismatch_total++;
    end else begin
      e = dtc_q.pop_front();
      compare_field("result_kind", 16'(e.kind), 16'(out_tuser));
      compare_field("code_raw", e.raw, out_tdata[15:0]);
      compare_field("system_letter", 16'(e.letter), 16'(out_tdata[23:16]));
      compare_field("group_digit", 16'(e.group), 16'(out_tdata[31:24]));
      compare_field("hex_char_high", 16'(e.hex_hi), 16'(out_tdata[39:32]));
      compare_field("hex_char_mid", 16'(e.hex_mid), 16'(out_tdata[47:40]));
      compare_field("hex_char_low", 16'(e.hex_lo), 16'(out_tdata[55:48]));
      compare_field("codes_found", 16'(e.found), 16'(out_tdata[61:56]));
      compare_field("tdata_pad", 16'h0000, 16'(out_tdata[63:62]));
      compare_field("last_of_run", 16'(e.last), 16'(out_tlast));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      code_limit = otce_pkg::MAX_CODES_RST;
      clear_parser();
      dtc_q.delete();
    end else begin
      if (cfg_we) code_limit = cfg_wdata;
      if (in_tvalid && in_tready) step_char(in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_result();
    end
    results_due <= dtc_q.size();
  end

endmodule

[verif/tb_obd_trouble_code_extractor.sv]
// ----------------------------------------------------------------------------
// tb_obd_trouble_code_extractor
// drives response text into the trouble code extractor: a short directed
// burst, then random responses (mostly well-formed with random codes, line
// numbers and separators, some noise) under several max_codes settings and
// three back-pressure modes; the checker predicts and compares the results
// ----------------------------------------------------------------------------
module tb_obd_trouble_code_extractor;

  localparam int CYCLE_LIMIT  = 400000;  // far above the slowest legal run
  localparam int DRAIN_CYCLES = 16;      // result queue plus pipeline slack
  localparam int PHASE_CHARS  = 260;     // six phases, about 1650 characters

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_wdata = '0;

  int fail_count;
  int results_due;
  int cycle_count = 0;
  int src_idle_pct = 22;   // chance per cycle that the sender holds off
  int sink_idle_pct = 53;  // chance per cycle that the receiver stalls
  int phase_chars;

  logic [7:0] text_buf[$];

  // clock, period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  obd_trouble_code_extractor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  otce_result_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one character transaction; tvalid stays up when the next one follows
  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_text(input string s, input logic last_at_end);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], last_at_end && (i == s.len() - 1));
  endtask

  task automatic send_buffer;
    foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1);
    phase_chars += text_buf.size();
  endtask

  // park the input and let every expected result come out
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_code_limit(input logic [5:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] nibble_char(input logic [3:0] v, input logic lower);
    if (v < 4'd10) return otce_pkg::CH_ZERO + {4'd0, v};
    if (lower) return otce_pkg::CH_LA + {4'd0, v} - 8'd10;
    return otce_pkg::CH_UA + {4'd0, v} - 8'd10;
  endfunction

  function automatic logic [7:0] noise_char;
    case ($urandom_range(13))
      0: return otce_pkg::CH_ZERO;
      1: return otce_pkg::CH_NINE;
      2: return otce_pkg::CH_UA;
      3: return otce_pkg::CH_LF_HEX;
      4: return otce_pkg::CH_COLON;
      5: return otce_pkg::CH_SPACE;
      6: return otce_pkg::CH_TAB;
      7: return otce_pkg::CH_CR;
      8: return otce_pkg::CH_LF;
      9: return "4";
      10: return "G";
      11: return ">";
      12: return otce_pkg::CH_NUL;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic lower);
    text_buf.push_back(nibble_char(b[7:4], lower));
    text_buf.push_back(nibble_char(b[3:0], lower));
    case ($urandom_range(7))
      0, 1: ;
      7: text_buf.push_back(otce_pkg::CH_TAB);
      default: text_buf.push_back(otce_pkg::CH_SPACE);
    endcase
  endtask

  // new line, sometimes after a dangling half byte, often with a line number
  task automatic maybe_break(input logic lower);
    if ($urandom_range(5) == 0) begin
      if ($urandom_range(9) == 0) text_buf.push_back(nibble_char(4'($urandom), lower));
      text_buf.push_back(otce_pkg::CH_CR);
      if ($urandom_range(1) == 1) text_buf.push_back(otce_pkg::CH_LF);
      if ($urandom_range(2) != 0) begin
        text_buf.push_back(otce_pkg::CH_ZERO + 8'($urandom_range(9)));
        text_buf.push_back(otce_pkg::CH_COLON);
        text_buf.push_back(otce_pkg::CH_SPACE);
      end
    end
  endtask

  task automatic compose_response;
    int          n_codes;
    logic [15:0] code;
    logic        lower;
    text_buf.delete();
    if ($urandom_range(99) < 75) begin
      // well-formed reply: header then code pairs
      lower = ($urandom_range(3) == 0);
      if ($urandom_range(2) == 0) begin
        text_buf.push_back(otce_pkg::CH_ZERO + 8'($urandom_range(9)));
        text_buf.push_back(otce_pkg::CH_COLON);
      end
      if ($urandom_range(7) == 0) put_byte(8'($urandom), lower);
      case ($urandom_range(2))
        0: put_byte(otce_pkg::HDR_STORED, lower);
        1: put_byte(otce_pkg::HDR_PENDING, lower);
        default: put_byte(otce_pkg::HDR_PERM, lower);
      endcase
      // rare long replies can run into the byte limit
      n_codes = ($urandom_range(19) == 0) ? $urandom_range(20, 36) : $urandom_range(0, 5);
      repeat (n_codes) begin
        case ($urandom_range(7))
          0: code = 16'h0000;
          1: code = 16'hFFFF;
          default: code = 16'($urandom);
        endcase
        put_byte(code[15:8], lower);
        maybe_break(lower);
        put_byte(code[7:0], lower);
        maybe_break(lower);
      end
      if ($urandom_range(4) == 0) put_byte(8'($urandom), lower);
      if ($urandom_range(5) == 0) text_buf.push_back(nibble_char(4'($urandom), lower));
      if ($urandom_range(14) == 0)
        text_buf.insert($urandom_range(text_buf.size()), otce_pkg::CH_NUL);
      case ($urandom_range(3))
        1: text_buf.push_back(otce_pkg::CH_CR);
        2: text_buf.push_back(">");
        3: text_buf.push_back(otce_pkg::CH_ZERO + 8'($urandom_range(9)));
        default: ;
      endcase
    end else begin
      // noise and broken fragments
      repeat ($urandom_range(1, 10)) begin
        if ($urandom_range(1) == 1) text_buf.push_back(8'($urandom_range(255)));
        else text_buf.push_back(noise_char());
      end
    end
  endtask

  initial begin
    logic [5:0] limit_plan [6];
    limit_plan = '{6'd1, 6'd32, 6'd3, 6'd32, 6'd2, 6'd1};
    limit_plan[4] = 6'($urandom_range(1, 32));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: line number, header 4A, blanks, zero pair, half byte cut by
    // a line end, all-ones code closing on the end flag
    send_text("0:4A 0000\t4\015FFFF", 1'b1);
    // directed: lower case hex, held digit used at NUL, text after NUL
    // ignored, all-ones character carrying the end flag
    send_text("47c100", 1'b0);
    send_char(otce_pkg::CH_NUL, 1'b0);
    send_char(8'hFF, 1'b1);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin
          src_idle_pct  = 22;
          sink_idle_pct = 53;
        end
        1: begin
          src_idle_pct  = 53;
          sink_idle_pct = 22;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      write_code_limit(limit_plan[p]);
      phase_chars = 0;
      while (phase_chars < PHASE_CHARS) begin
        compose_response();
        send_buffer();
      end
      drain();
    end

    if (fail_count == 0 && results_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
